[hw/rtl/hwss_pkg.sv]
// Shared constants, types and helpers for the health-weighted server selector.
package hwss_pkg;

  localparam int NUM_SERVERS    = 4;
  localparam int WINDOW_SAMPLES = 8;

  localparam int LAT_W      = 16;
  localparam int SRV_W      = 2;
  localparam int SEL_W      = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int ERR_W      = 8;
  localparam int WGT_W      = 8;
  localparam int PTR_W      = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int FILL_W     = $clog2(WINDOW_SAMPLES + 1);
  localparam int WIN_DEPTH  = NUM_SERVERS * WINDOW_SAMPLES;
  localparam int WIN_AW     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int SUM_W      = LAT_W + FILL_W;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);
  localparam int PROD_W     = WGT_W + LAT_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] MODE_SELECT  = 2'd0;
  localparam logic [1:0] MODE_SUCCESS = 2'd1;
  localparam logic [1:0] MODE_FAILURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ERROR_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED_MASK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ZERO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE    = 3'd5;

  localparam logic [ERR_W-1:0] ERR_MAX = '1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SRV_W-1:0] server_index;
    logic [LAT_W-1:0] latency_ms;
  } request_t;

  typedef struct packed {
    logic [SRV_W-1:0] chosen_server;
    logic             health_reset;
    logic             marked_unhealthy;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FAIL,
    ST_WRITE,
    ST_SUM,
    ST_DIV,
    ST_SELECT,
    ST_FINISH
  } state_t;

  function automatic logic [WIN_AW-1:0] win_addr(input logic [SRV_W-1:0] srv,
                                                 input logic [PTR_W-1:0] slot);
    win_addr = WIN_AW'(srv) * WIN_AW'(WINDOW_SAMPLES) + WIN_AW'(slot);
  endfunction

endpackage

[hw/rtl/health_weighted_server_selector.sv]
// Top level of the health-weighted server selector: sequencer, statistics and selection.
// A selection walks the servers once and then finishes. A failure report first updates
// the error count and health flag; a success report first writes, sums and averages the window.
// The divider yields one quotient bit per cycle and the walk compares one server per cycle.
// A new transaction is accepted in the cycle that done is high; results cannot be stalled.
// Synchronous reset restores the register defaults and clears all server statistics.
module health_weighted_server_selector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  hwss_pkg::request_t               request,
  output logic                             done,
  output hwss_pkg::result_t                result,
  input  logic                             cfg_write,
  input  logic [hwss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hwss_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import hwss_pkg::*;

  state_t state, state_next;

  request_t req;

  logic [ERR_W-1:0]       err_thr;
  logic [NUM_SERVERS-1:0] en_mask;
  logic [WGT_W-1:0]       wgt     [NUM_SERVERS];
  logic [FILL_W-1:0]      fill    [NUM_SERVERS];
  logic [PTR_W-1:0]       ptr     [NUM_SERVERS];
  logic [LAT_W-1:0]       avg     [NUM_SERVERS];
  logic [ERR_W-1:0]       err     [NUM_SERVERS];
  logic [NUM_SERVERS-1:0] healthy;

  logic [FILL_W-1:0]    rd_idx;
  logic                 rd_pend;
  logic [SUM_W-1:0]     acc;
  logic [SUM_W-1:0]     quo;
  logic [FILL_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SEL_W-1:0]     sel_idx;
  logic [SEL_W-1:0]     chosen;
  logic                 found;
  logic                 marked;

  logic                 ram_we;
  logic [WIN_AW-1:0]    ram_waddr;
  logic [WIN_AW-1:0]    ram_raddr;
  logic [LAT_W-1:0]     ram_rdata;

  logic [FILL_W-1:0]    fill_cur;

  logic [FILL_W:0]      rem_sh;
  logic                 div_ge;
  logic [FILL_W-1:0]    rem_new;
  logic [SUM_W-1:0]     quo_new;
  logic [ERR_W-1:0]     err_inc;
  logic                 cand;
  logic [PROD_W-1:0]    lhs;
  logic [PROD_W-1:0]    rhs;
  logic                 sum_done;

  assign fill_cur  = fill[req.server_index];
  assign ram_we    = (state == ST_WRITE);
  assign ram_waddr = win_addr(req.server_index, ptr[req.server_index]);
  assign ram_raddr = win_addr(req.server_index, rd_idx[PTR_W-1:0]);
  assign sum_done  = (rd_idx == fill_cur) && !rd_pend;

  assign rem_sh  = {rem, quo[SUM_W-1]};
  assign div_ge  = (rem_sh >= {1'b0, fill_cur});
  assign rem_new = div_ge ? FILL_W'(rem_sh - {1'b0, fill_cur}) : FILL_W'(rem_sh);
  assign quo_new = {quo[SUM_W-2:0], div_ge};

  assign err_inc = (err[req.server_index] == ERR_MAX) ? ERR_MAX
                                                      : err[req.server_index] + 1'b1;

  assign cand = en_mask[sel_idx] && healthy[sel_idx];
  assign lhs  = PROD_W'(wgt[sel_idx]) * (PROD_W'(avg[chosen]) + PROD_W'(1));
  assign rhs  = PROD_W'(wgt[chosen]) * (PROD_W'(avg[sel_idx]) + PROD_W'(1));

  hwss_ram #(
    .WIDTH (LAT_W),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.latency_ms),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (request.mode == MODE_SUCCESS) begin
            state_next = ST_WRITE;
          end else if (request.mode == MODE_FAILURE) begin
            state_next = ST_FAIL;
          end else begin
            state_next = ST_SELECT;
          end
        end
      end
      ST_FAIL:  state_next = ST_SELECT;
      ST_WRITE: state_next = ST_SUM;
      ST_SUM: begin
        if (sum_done) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(SUM_W - 1)) begin
          state_next = ST_SELECT;
        end
      end
      ST_SELECT: begin
        if (sel_idx == SEL_W'(NUM_SERVERS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_thr <= ERR_W'(3);
      en_mask <= '1;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        wgt[i] <= WGT_W'(1);
      end
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ERROR_THRESHOLD: err_thr <= cfg_data[ERR_W-1:0];
        REG_ENABLED_MASK:    en_mask <= cfg_data[NUM_SERVERS-1:0];
        REG_WEIGHT_ZERO:     wgt[0]  <= cfg_data[WGT_W-1:0];
        REG_WEIGHT_ONE:      wgt[1]  <= cfg_data[WGT_W-1:0];
        REG_WEIGHT_TWO:      wgt[2]  <= cfg_data[WGT_W-1:0];
        REG_WEIGHT_THREE:    wgt[3]  <= cfg_data[WGT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      healthy <= '1;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        fill[i] <= '0;
        ptr[i]  <= '0;
        avg[i]  <= '0;
        err[i]  <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            req     <= request;
            marked  <= 1'b0;
            sel_idx <= '0;
            chosen  <= '0;
            found   <= 1'b0;
          end
        end
        ST_FAIL: begin
          err[req.server_index] <= err_inc;
          if (err_inc > err_thr) begin
            healthy[req.server_index] <= 1'b0;
            marked <= healthy[req.server_index];
          end
        end
        ST_WRITE: begin
          ptr[req.server_index] <= (ptr[req.server_index] == PTR_W'(WINDOW_SAMPLES - 1))
                                   ? '0 : ptr[req.server_index] + 1'b1;
          if (fill_cur != FILL_W'(WINDOW_SAMPLES)) begin
            fill[req.server_index] <= fill_cur + 1'b1;
          end
          err[req.server_index]     <= '0;
          healthy[req.server_index] <= 1'b1;
          rd_idx  <= '0;
          rd_pend <= 1'b0;
          acc     <= '0;
        end
        ST_SUM: begin
          if (rd_idx != fill_cur) begin
            rd_idx  <= rd_idx + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            acc <= acc + SUM_W'(ram_rdata);
          end
          if (sum_done) begin
            quo     <= acc;
            rem     <= '0;
            div_cnt <= '0;
          end
        end
        ST_DIV: begin
          quo     <= quo_new;
          rem     <= rem_new;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(SUM_W - 1)) begin
            avg[req.server_index] <= quo_new[LAT_W-1:0];
          end
        end
        ST_SELECT: begin
          sel_idx <= sel_idx + 1'b1;
          if (cand) begin
            if (!found) begin
              chosen <= sel_idx;
              found  <= 1'b1;
            end else if (lhs > rhs) begin
              chosen <= sel_idx;
            end
          end
        end
        ST_FINISH: begin
          done                    <= 1'b1;
          result.marked_unhealthy <= marked;
          result.health_reset     <= !found;
          result.chosen_server    <= found ? SRV_W'(chosen) : '0;
          if (!found) begin
            for (int i = 0; i < NUM_SERVERS; i++) begin
              if (en_mask[i]) begin
                healthy[i] <= 1'b1;
                err[i]     <= '0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not make the block busy");

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("done strobe without a finishing step");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> fill_cur != '0)
    else $error("average computed over an empty window");

endmodule

[hw/rtl/hwss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hwss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
